// File: design/activation_function_unit_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the activation function unit
// Short forms of the concurrent assertions used by the unit's port checker.
// ----------------------------------------------------------------------------
`ifndef ACTIVATION_FUNCTION_UNIT_CORE_MACROS_SVH
`define ACTIVATION_FUNCTION_UNIT_CORE_MACROS_SVH

// Property checked at every rising edge, switched off while reset is held.
`define AFU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define AFU_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/afu_pkg.sv
// ----------------------------------------------------------------------------
// Activation function unit package
// Mode codes, widths and the sigmoid table, built at elaboration in fixed point.
// ----------------------------------------------------------------------------
package afu_pkg;

	// Number of interpolation segments over |x| in [0, 8).
	localparam int SEGMENTS = 64;
	localparam int IDX_W    = $clog2(SEGMENTS + 1);
	localparam int FRAC_W   = 15;
	localparam int POS_W    = FRAC_W + IDX_W;
	localparam int ROM_W    = 12;
	localparam int SIG_W    = 13;
	localparam int PROD_W   = 2 * SIG_W;

	localparam logic [SIG_W-1:0] Q12_ONE = 13'd4096;

	typedef enum logic [2:0] {
		MODE_SIGMOID   = 3'd0,
		MODE_SIGMOID_D = 3'd1,
		MODE_RELU      = 3'd2,
		MODE_RELU_D    = 3'd3,
		MODE_TANH      = 3'd4,
		MODE_TANH_D    = 3'd5,
		MODE_IDENTITY  = 3'd6,
		MODE_ONE       = 3'd7
	} mode_t;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} stage_en_t;

	typedef logic [ROM_W-1:0] rom_word_t;
	typedef rom_word_t [SEGMENTS:0] rom_arr_t;

	localparam logic [63:0] FX_ONE  = 64'h4000_0000_0000_0000;
	localparam logic [63:0] FX_HALF = 64'h2000_0000_0000_0000;

	// Rounded product of two Q2.62 values, built from 32-bit partial products.
	function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
		logic [63:0] ah, al, bh, bl, ll, lh, hl, hh, mid, lo, hi, lo2;
		ah  = a >> 32;
		al  = a & 64'h0000_0000_FFFF_FFFF;
		bh  = b >> 32;
		bl  = b & 64'h0000_0000_FFFF_FFFF;
		ll  = al * bl;
		lh  = al * bh;
		hl  = ah * bl;
		hh  = ah * bh;
		mid = (ll >> 32) + (lh & 64'h0000_0000_FFFF_FFFF) + (hl & 64'h0000_0000_FFFF_FFFF);
		lo  = (ll & 64'h0000_0000_FFFF_FFFF) | (mid << 32);
		hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
		lo2 = lo + FX_HALF;
		if (lo2 < lo) begin
			hi = hi + 64'd1;
		end
		return (hi << 2) | (lo2 >> 62);
	endfunction

	// Restoring division, used only while the table is built.
	function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// round(4096 / (1 + p)) for p in Q2.62 within (0, 1].
	function automatic rom_word_t fx_sig_q12(logic [63:0] p);
		logic [63:0] d, q, r;
		d = FX_ONE + p;
		q = (p == 64'd0) ? 64'd1 : 64'd0;
		r = (p == 64'd0) ? 64'd0 : FX_ONE;
		for (int i = 0; i < 13; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r    = r - d;
				q[0] = 1'b1;
			end
		end
		return ROM_W'((q + 64'd1) >> 1);
	endfunction

	// Sigmoid at the segment ends: exp(-8/SEGMENTS) by series, then powers of it.
	function automatic rom_arr_t build_rom();
		rom_arr_t    rom;
		logic [63:0] y, term, e, p;
		y    = (FX_ONE / SEGMENTS) * 64'd8 + ((FX_ONE % SEGMENTS) * 64'd8) / SEGMENTS;
		term = FX_ONE;
		e    = FX_ONE;
		p    = FX_ONE;
		for (int n = 1; n <= 40; n++) begin
			term = div_u64(fx_mul(term, y), 64'(n));
			if (n % 2 == 1) begin
				e = e - term;
			end else begin
				e = e + term;
			end
		end
		for (int k = 0; k <= SEGMENTS; k++) begin
			rom[k] = fx_sig_q12(p);
			p      = fx_mul(p, e);
		end
		return rom;
	endfunction

	localparam rom_arr_t SIG_ROM = build_rom();

endpackage

// File: design/activation_function_unit_core.sv
// ----------------------------------------------------------------------------
// Activation function unit core
// Five-stage Q4.12 activation pipeline: sigmoid, tanh, ReLU and derivatives.
// ----------------------------------------------------------------------------
// Usage
// The input channel carries one signed Q4.12 sample on x_in; a transfer takes
// place on a rising edge where in_valid is high and in_stall is low. The
// output channel returns one signed Q4.12 result on y_out for every sample,
// in order, transferred on an edge where out_valid is high and out_stall low.
// The function is chosen by the three-bit mode register, written through
// mode_we and mode_wdata; it should only be changed while the pipeline is
// empty, and each sample carries the mode that was current when it entered.
// A transferred sample passes through the pipeline registers in stage order
// and is offered on y_out from the last one. Throughput is one sample per
// cycle while the output is not stalled, set by the five pipeline registers,
// each of which can take a new sample as soon as its current one moves on.
// When the receiver stalls, the result is held in the output register and
// the stages behind it keep filling their bubbles; in_stall rises only once
// every stage holds a sample. Reset clears all stage valid bits and sets the
// mode to sigmoid; it takes effect at once and nothing is in flight after it.
// ----------------------------------------------------------------------------
module activation_function_unit_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mode_we,
	input  logic [2:0]         mode_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] x_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] y_out
);

	// Mode register.
	afu_pkg::mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= afu_pkg::MODE_SIGMOID;
		end else if (mode_we) begin
			mode_q <= afu_pkg::mode_t'(mode_wdata);
		end
	end

	// Pipeline flow control. A stage may load when it is empty or when the
	// sample it holds moves on at the same edge.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	assign rdy_s5   = !v_s5 || !out_stall;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// Stage 1: the argument of the sigmoid. Tanh works on 2x, saturated to
	// 16 bits, and the magnitude is split into a segment index and fraction.
	logic                             tanh_mode;
	logic signed [15:0]               arg;
	logic [15:0]                      mag;
	logic [afu_pkg::POS_W-1:0]        pos;

	logic [afu_pkg::IDX_W-1:0]        idx_s1;
	logic [afu_pkg::FRAC_W-1:0]       frac_s1;
	logic                             neg_s1;
	afu_pkg::mode_t                   mode_s1;
	logic signed [15:0]               x_s1;

	assign tanh_mode = (mode_q == afu_pkg::MODE_TANH) || (mode_q == afu_pkg::MODE_TANH_D);

	always_comb begin
		if (!tanh_mode) begin
			arg = x_in;
		end else if (x_in[15:14] == 2'b01) begin
			arg = 16'sh7FFF;
		end else if (x_in[15:14] == 2'b10) begin
			arg = -16'sh8000;
		end else begin
			arg = {x_in[14:0], 1'b0};
		end
	end

	// The most negative sample gives a magnitude of exactly 8.0, which lands
	// on the last table point.
	assign mag = arg[15] ? (~arg + 16'd1) : arg;
	assign pos = afu_pkg::POS_W'(mag) * afu_pkg::POS_W'(afu_pkg::SEGMENTS);

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			idx_s1  <= pos[afu_pkg::POS_W-1:afu_pkg::FRAC_W];
			frac_s1 <= pos[afu_pkg::FRAC_W-1:0];
			neg_s1  <= arg[15];
			mode_s1 <= mode_q;
			x_s1    <= x_in;
		end
	end

	// Stages 2 and 3: table read and interpolation; mode and sample ride along.
	afu_pkg::stage_en_t        sig_en;
	logic [afu_pkg::SIG_W-1:0] sg_s3;
	afu_pkg::mode_t            mode_s2, mode_s3;
	logic signed [15:0]        x_s2, x_s3;

	assign sig_en.en_s2 = rdy_s2 && v_s1;
	assign sig_en.en_s3 = rdy_s3 && v_s2;

	afu_sig_interp u_sig_interp (
		.clk  (clk),
		.en   (sig_en),
		.idx  (idx_s1),
		.frac (frac_s1),
		.neg  (neg_s1),
		.sg   (sg_s3)
	);

	always_ff @(posedge clk) begin
		if (sig_en.en_s2) begin
			mode_s2 <= mode_s1;
			x_s2    <= x_s1;
		end
		if (sig_en.en_s3) begin
			mode_s3 <= mode_s2;
			x_s3    <= x_s2;
		end
	end

	// Stage 4: tanh from the sigmoid, the product for the sigmoid and tanh
	// derivatives, and the finished result for every mode that needs no product.
	logic signed [14:0]          t_val;
	logic [afu_pkg::SIG_W-1:0]   t_mag;
	logic [afu_pkg::SIG_W-1:0]   mul_a, mul_b;
	logic signed [15:0]          direct;

	logic [afu_pkg::PROD_W-1:0]  prod_s4;
	logic signed [15:0]          direct_s4;
	afu_pkg::mode_t              mode_s4;

	assign t_val = $signed({1'b0, sg_s3, 1'b0}) - 15'sd4096;
	assign t_mag = t_val[14] ? afu_pkg::SIG_W'(-t_val) : afu_pkg::SIG_W'(t_val);

	always_comb begin
		if (mode_s3 == afu_pkg::MODE_SIGMOID_D) begin
			mul_a = sg_s3;
			mul_b = afu_pkg::Q12_ONE - sg_s3;
		end else begin
			mul_a = t_mag;
			mul_b = t_mag;
		end
	end

	always_comb begin
		direct = '0;
		unique case (mode_s3)
			afu_pkg::MODE_SIGMOID:   direct = {3'b000, sg_s3};
			afu_pkg::MODE_SIGMOID_D: direct = '0;
			afu_pkg::MODE_RELU:      direct = x_s3[15] ? 16'sd0 : x_s3;
			afu_pkg::MODE_RELU_D:    direct = (!x_s3[15] && (x_s3 != 16'sd0)) ? 16'sd4096 : 16'sd0;
			afu_pkg::MODE_TANH:      direct = {t_val[14], t_val};
			afu_pkg::MODE_TANH_D:    direct = '0;
			afu_pkg::MODE_IDENTITY:  direct = x_s3;
			afu_pkg::MODE_ONE:       direct = 16'sd4096;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			prod_s4   <= mul_a * mul_b;
			direct_s4 <= direct;
			mode_s4   <= mode_s3;
		end
	end

	// Stage 5: rounding of the product and the output register.
	logic [afu_pkg::PROD_W:0] prod_rnd;
	logic [14:0]              sq_q12;
	logic signed [15:0]       y_next;
	logic signed [15:0]       y_s5;

	assign prod_rnd = {1'b0, prod_s4} + (afu_pkg::PROD_W + 1)'(2048);
	assign sq_q12   = prod_rnd[afu_pkg::PROD_W:12];

	always_comb begin
		case (mode_s4)
			afu_pkg::MODE_SIGMOID_D: y_next = {1'b0, sq_q12};
			afu_pkg::MODE_TANH_D:    y_next = 16'sd4096 - $signed({1'b0, sq_q12});
			default:                 y_next = direct_s4;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			y_s5 <= y_next;
		end
	end

	assign out_valid = v_s5;
	assign y_out     = y_s5;

endmodule

// File: design/afu_sig_interp.sv
// ----------------------------------------------------------------------------
// Sigmoid interpolator
// Table read (stage 2) and rounded linear interpolation with sign fold (stage 3).
// ----------------------------------------------------------------------------
module afu_sig_interp (
	input  logic                             clk,
	input  afu_pkg::stage_en_t               en,
	input  logic [afu_pkg::IDX_W-1:0]        idx,
	input  logic [afu_pkg::FRAC_W-1:0]       frac,
	input  logic                             neg,
	output logic [afu_pkg::SIG_W-1:0]        sg
);

	logic [afu_pkg::IDX_W-1:0]  hi_idx;
	afu_pkg::rom_word_t         lo_rd;
	afu_pkg::rom_word_t         hi_rd;

	afu_pkg::rom_word_t         lo_s2;
	afu_pkg::rom_word_t         diff_s2;
	logic [afu_pkg::FRAC_W-1:0] frac_s2;
	logic                       neg_s2;

	logic [afu_pkg::ROM_W+afu_pkg::FRAC_W:0] rnd;
	logic [afu_pkg::SIG_W-1:0]               mag_sig;
	logic [afu_pkg::SIG_W-1:0]               sg_s3;

	// The last point has no right neighbour; its fraction is always zero.
	assign hi_idx = (idx == afu_pkg::IDX_W'(afu_pkg::SEGMENTS)) ? idx : idx + 1'b1;
	assign lo_rd  = afu_pkg::SIG_ROM[idx];
	assign hi_rd  = afu_pkg::SIG_ROM[hi_idx];

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			lo_s2   <= lo_rd;
			diff_s2 <= hi_rd - lo_rd;
			frac_s2 <= frac;
			neg_s2  <= neg;
		end
	end

	assign rnd     = (afu_pkg::ROM_W + afu_pkg::FRAC_W + 1)'(diff_s2 * frac_s2)
	               + (afu_pkg::ROM_W + afu_pkg::FRAC_W + 1)'(16384);
	assign mag_sig = {1'b0, lo_s2} + rnd[afu_pkg::ROM_W+afu_pkg::FRAC_W:afu_pkg::FRAC_W];

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			sg_s3 <= neg_s2 ? (afu_pkg::Q12_ONE - mag_sig) : mag_sig;
		end
	end

	assign sg = sg_s3;

endmodule

// File: design/afu_checker.sv
// ----------------------------------------------------------------------------
// Activation function unit port checker
// Concurrent checks on the unit's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "activation_function_unit_core_macros.svh"

module afu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        mode_we,
	input logic [2:0]  mode_wdata,
	input logic        in_valid,
	input logic        in_stall,
	input logic [15:0] x_in,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] y_out
);

	// A stalled result stays offered and unchanged.
	`AFU_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(y_out), "stalled result changed or vanished")

	// The input can only be held off when a result is waiting at the output.
	`AFU_ASSERT_ALWAYS(a_stall_needs_full, clk, !out_valid |-> !in_stall, "input stalled with an empty output register")

	// Once reset has been seen at an edge, nothing is offered at the next one.
	`AFU_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !out_valid, "result offered after reset")

	// With the output unstalled meanwhile, a transfer in is followed by a result.
	`AFU_ASSERT(a_latency, clk, arst_n, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid, "result missing after pipeline latency")

endmodule

bind activation_function_unit_core afu_checker u_afu_checker (.*);

// File: sim/tb_activation_function_unit_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the activation function unit core
// Sends Q4.12 samples under every mode setting with random gaps and output
// stalls, works out each result with an independent fixed-point sigmoid table
// and checks every returned result, in order, against the expected one.
// ----------------------------------------------------------------------------
module tb_activation_function_unit_core;

	// Interpolation grid and fixed-point units used by the predictor.
	localparam int          SIG_SEGS   = 64;
	localparam int          UNIT_Q12   = 4096;
	localparam logic [63:0] Q62_UNIT   = 64'h4000_0000_0000_0000;
	// Cycles without any transfer before the run is declared hung.
	localparam int          QUIET_LIMIT = 2000;
	// Results returned before the receiver holds off for a long stretch.
	localparam int          HOLD_AFTER  = 300;
	localparam int          HOLD_CYCLES = 150;

	// Every input is given a known value from time zero.
	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               mode_we    = 1'b0;
	logic [2:0]         mode_wdata = afu_pkg::MODE_SIGMOID;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic signed [15:0] x_in       = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic signed [15:0] y_out;

	// One expected result, with the sample and mode that produced it so that
	// a mismatch report says what went in.
	typedef struct {
		logic signed [15:0] x;
		afu_pkg::mode_t     m;
		logic signed [15:0] y;
	} act_result_t;

	logic [15:0]        sig_table [0:SIG_SEGS];
	logic signed [15:0] sample_q [$];
	act_result_t        result_q [$];
	afu_pkg::mode_t     mode_shadow = afu_pkg::MODE_SIGMOID;
	int                 mismatches  = 0;
	int                 out_count   = 0;
	int                 send_gap    = 0;
	int                 send_burst  = 0;
	int                 stall_left  = 0;
	int                 stall_burst = 0;
	int                 hold_left   = 0;
	bit                 hold_done   = 1'b0;
	int                 quiet       = 0;

	activation_function_unit_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode_we   (mode_we),
		.mode_wdata(mode_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_in      (x_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.y_out     (y_out)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Sigmoid table
	// ------------------------------------------------------------------------

	// Rounded product of two Q2.62 numbers, taken from the full 128-bit product.
	function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b} + (128'd1 << 61);
		return prod[125:62];
	endfunction

	// round(4096 / (1 + p)) for p in Q2.62; the quotient carries one extra
	// bit, which does the rounding half up.
	function automatic logic [15:0] sig_point(logic [63:0] p);
		logic [127:0] den, quo;
		den = {64'd0, Q62_UNIT + p};
		quo = ({64'd0, Q62_UNIT} << 13) / den;
		return 16'((quo + 128'd1) >> 1);
	endfunction

	// The table points are sigmoid(8k/SIG_SEGS). The factor exp(-8/SIG_SEGS)
	// comes from a forty-term series and its powers give each point in turn.
	task automatic fill_sig_table();
		logic [63:0] step, term, decay, p;
		step  = (Q62_UNIT / SIG_SEGS) * 64'd8 + ((Q62_UNIT % SIG_SEGS) * 64'd8) / SIG_SEGS;
		term  = Q62_UNIT;
		decay = Q62_UNIT;
		p     = Q62_UNIT;
		for (int n = 1; n <= 40; n++) begin
			term = q62_mul(term, step) / 64'(n);
			if (n % 2 == 1) begin
				decay = decay - term;
			end else begin
				decay = decay + term;
			end
		end
		for (int k = 0; k <= SIG_SEGS; k++) begin
			sig_table[k] = sig_point(p);
			p            = q62_mul(p, decay);
		end
	endtask

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Sigmoid of a sample by linear interpolation over |x|. A magnitude of
	// exactly 8.0 (only the most negative sample) lands past the last segment
	// and reads the final table point as it stands. Negative samples use
	// sigmoid(-x) = 1 - sigmoid(x).
	function automatic int sigmoid_fix(int x);
		int unsigned mag, pos, seg, frac;
		longint      lo, hi, acc;
		int          s;
		mag  = (x < 0) ? -x : x;
		pos  = mag * SIG_SEGS;
		seg  = pos >> 15;
		frac = pos & 32'h7FFF;
		if (seg >= SIG_SEGS) begin
			s = sig_table[SIG_SEGS];
		end else begin
			lo  = sig_table[seg];
			hi  = sig_table[seg + 1];
			acc = lo * 32768 + (hi - lo) * longint'(frac) + 16384;
			s   = int'(acc >>> 15);
		end
		return (x < 0) ? UNIT_Q12 - s : s;
	endfunction

	// tanh(x) = 2*sigmoid(2x) - 1, with the doubled sample clipped to 16 bits.
	function automatic int tanh_fix(int x);
		int x2;
		x2 = 2 * x;
		if (x2 > 32767) begin
			x2 = 32767;
		end else if (x2 < -32768) begin
			x2 = -32768;
		end
		return 2 * sigmoid_fix(x2) - UNIT_Q12;
	endfunction

	function automatic logic signed [15:0] activation_of(afu_pkg::mode_t m,
		logic signed [15:0] x);
		int xi, r, s, t;
		xi = x;
		case (m)
			afu_pkg::MODE_SIGMOID: begin
				r = sigmoid_fix(xi);
			end
			afu_pkg::MODE_SIGMOID_D: begin
				s = sigmoid_fix(xi);
				r = (s * (UNIT_Q12 - s) + 2048) >>> 12;
			end
			afu_pkg::MODE_RELU: begin
				r = (xi > 0) ? xi : 0;
			end
			afu_pkg::MODE_RELU_D: begin
				r = (xi > 0) ? UNIT_Q12 : 0;
			end
			afu_pkg::MODE_TANH: begin
				r = tanh_fix(xi);
			end
			afu_pkg::MODE_TANH_D: begin
				t = tanh_fix(xi);
				r = UNIT_Q12 - ((t * t + 2048) >>> 12);
			end
			afu_pkg::MODE_IDENTITY: begin
				r = xi;
			end
			default: begin
				r = UNIT_Q12;
			end
		endcase
		return 16'(r);
	endfunction

	// ------------------------------------------------------------------------
	// Random shaping
	// ------------------------------------------------------------------------

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Samples are spread over the whole 16-bit range, the region where the
	// curves bend, the segment boundaries of the table and the corners.
	function automatic logic signed [15:0] random_sample();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
			3, 4:    v = int'($urandom_range(0, 8191)) - 4096;
			5:       v = int'($urandom_range(0, 32767)) - 16384;
			6, 7: begin
				v = int'($urandom_range(0, SIG_SEGS - 1)) * 512 + int'($urandom_range(0, 4)) - 2;
				if ($urandom_range(0, 1) == 1) begin
					v = -v;
				end
			end
			8: begin
				case ($urandom_range(0, 11))
					0:       v = -32768;
					1:       v = -32767;
					2:       v = -1;
					3:       v = 0;
					4:       v = 1;
					5:       v = 32766;
					6:       v = 32767;
					7:       v = 16383;
					8:       v = 16384;
					9:       v = -16384;
					10:      v = -16385;
					default: v = -16383;
				endcase
			end
			default: v = int'($urandom_range(0, 127)) - 64;
		endcase
		return 16'(v);
	endfunction

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------
	// At each edge the sender first records a transfer, if one took place,
	// together with the result it should produce under the current mode. It
	// then moves on only if the slot is free: a stalled sample stays on x_in
	// with in_valid high until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				result_q.push_back('{x: x_in, m: mode_shadow,
					y: activation_of(mode_shadow, x_in)});
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					x_in     <= sample_q.pop_front();
					in_valid <= 1'b1;
					// Bursts with no gaps at all are mixed in now and then.
					if (send_burst > 0) begin
						send_burst--;
						send_gap = 0;
					end else begin
						send_gap = idle_len();
						if ($urandom_range(0, 49) == 0) begin
							send_burst = $urandom_range(20, 60);
						end
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver and checker
	// ------------------------------------------------------------------------
	// Each result transfer is compared with the oldest expectation. The stall
	// pattern is random, and once, after HOLD_AFTER results, the receiver
	// holds off for HOLD_CYCLES while the sender keeps offering, so the
	// pipeline fills completely and has to stall its input.
	always @(posedge clk) begin
		act_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_count++;
				if (result_q.size() == 0) begin
					mismatches++;
					$display("%0t: result %0d arrived with none expected", $time, y_out);
				end else begin
					want = result_q.pop_front();
					if (y_out !== want.y) begin
						mismatches++;
						$display("%0t: mode %s x=%0d: expected y=%0d, got y=%0d",
							$time, want.m.name(), want.x, want.y, y_out);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && out_count >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (stall_burst > 0) begin
					stall_burst--;
				end else begin
					stall_left = idle_len();
					if ($urandom_range(0, 49) == 0) begin
						stall_burst = $urandom_range(20, 60);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	// Counts cycles in which neither channel completes a transfer; the longest
	// correct quiet spell is the long hold-off plus a little.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Waits until every queued sample has been sent and every result has come
	// back, so the pipeline is empty, then idles on before the mode is
	// changed. Conditions are sampled on the falling edge, clear of the
	// updates made at the rising one.
	task automatic drain();
		do begin
			@(negedge clk);
		end while (sample_q.size() != 0 || in_valid || result_q.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic change_mode(afu_pkg::mode_t m);
		@(posedge clk);
		mode_we     <= 1'b1;
		mode_wdata  <= m;
		mode_shadow = m;
		@(posedge clk);
		mode_we     <= 1'b0;
	endtask

	initial begin
		afu_pkg::mode_t m;
		fill_sig_table();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: every mode in turn with the samples that matter most
		// to it, among them both ends of the range, the most negative sample
		// that reads the last table point directly, and samples whose doubled
		// value saturates in tanh.
		for (int k = 0; k < 8; k++) begin
			m = afu_pkg::mode_t'(k);
			change_mode(m);
			case (m)
				afu_pkg::MODE_SIGMOID: begin
					sample_q.push_back(16'sh8000);
					sample_q.push_back(16'sh7FFF);
					sample_q.push_back(16'sh0000);
				end
				afu_pkg::MODE_SIGMOID_D: begin
					sample_q.push_back(16'sh1000);
					sample_q.push_back(16'shEFFF);
					sample_q.push_back(16'sh8000);
				end
				afu_pkg::MODE_RELU: begin
					sample_q.push_back(16'sh0001);
					sample_q.push_back(16'shFFFF);
					sample_q.push_back(16'sh8000);
				end
				afu_pkg::MODE_RELU_D: begin
					sample_q.push_back(16'sh0001);
					sample_q.push_back(16'sh0000);
					sample_q.push_back(16'sh8000);
				end
				afu_pkg::MODE_TANH: begin
					sample_q.push_back(16'sh4000);
					sample_q.push_back(16'shBFFF);
					sample_q.push_back(16'sh7FFF);
				end
				afu_pkg::MODE_TANH_D: begin
					sample_q.push_back(16'sh8000);
					sample_q.push_back(16'sh1FFF);
					sample_q.push_back(16'sh0000);
				end
				afu_pkg::MODE_IDENTITY: begin
					sample_q.push_back(16'sh7FFF);
					sample_q.push_back(16'sh8000);
				end
				default: begin
					sample_q.push_back(16'sh0000);
					sample_q.push_back(16'sh3039);
				end
			endcase
			drain();
		end

		// Random part: every mode once in order, then two more picked at random,
		// with the pipeline emptied between settings.
		for (int ph = 0; ph < 10; ph++) begin
			if (ph < 8) begin
				m = afu_pkg::mode_t'(ph);
			end else begin
				m = afu_pkg::mode_t'($urandom_range(0, 7));
			end
			change_mode(m);
			repeat (53) sample_q.push_back(random_sample());
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
